// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the voice filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define VFD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define VFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define VFD_ASSERT(lbl, clk, rst_n, prop, msg)

`define VFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/vfd_pkg.sv
// ----------------------------------------------------------------------------
// Voice filter delay package
// Shared widths, register indexes, delay line request type and helpers.
// ----------------------------------------------------------------------------
package vfd_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int GAIN_BITS   = 16;
	localparam int OP_BITS     = 27;
	localparam int PROD_BITS   = GAIN_BITS + 1 + OP_BITS;
	localparam int POS_BITS    = 16;
	localparam int POS_SPAN    = 1 << POS_BITS;
	localparam int IDX_BITS    = 3;
	localparam int Q_GAIN      = 15;
	localparam int Q_VOL       = 12;

	localparam logic [IDX_BITS-1:0] REG_LEGACY_MODE    = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_SMOOTHING_GAIN = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_HIGHPASS_SHARE = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_INDUCTOR_RECIP = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_DELAY_GAIN     = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_DELAY_LENGTH   = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_VOICE_VOLUME   = 3'd6;

	localparam logic signed [PROD_BITS-1:0] SAT_HI =
		(PROD_BITS'(1) <<< (SAMPLE_BITS - 1)) - PROD_BITS'(1);
	localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);

	typedef struct packed {
		logic                   rd;
		logic                   wr;
		logic                   clr;
		logic [POS_BITS-1:0]    addr;
		logic [SAMPLE_BITS-1:0] wdata;
	} dl_req_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [PROD_BITS-1:0] v
	);
		logic signed [PROD_BITS-1:0] c;
		c = v;
		if (v > SAT_HI) begin
			c = SAT_HI;
		end else if (v < SAT_LO) begin
			c = SAT_LO;
		end
		return c[SAMPLE_BITS-1:0];
	endfunction

	// Round to nearest with ties toward plus infinity, then drop sh fraction bits.
	function automatic logic signed [PROD_BITS-1:0] round_shift(
		input logic signed [PROD_BITS-1:0] p,
		input int unsigned                 sh
	);
		logic signed [PROD_BITS-1:0] half;
		half = PROD_BITS'(1) <<< (sh - 1);
		return (p + half) >>> sh;
	endfunction

endpackage

// File: rtl/core/vfd_if.sv
// ----------------------------------------------------------------------------
// Voice filter delay channels
// Valid/ready channels for input samples and voice results.
// ----------------------------------------------------------------------------
interface vfd_in_if import vfd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface vfd_out_if import vfd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// File: rtl/core/vfd_mul.sv
// ----------------------------------------------------------------------------
// Shared gain multiplier
// Registered product of an unsigned gain and a signed operand.
// ----------------------------------------------------------------------------
module vfd_mul import vfd_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic [GAIN_BITS-1:0]        gain,
	input  logic signed [OP_BITS-1:0]   opnd,
	output logic signed [PROD_BITS-1:0] prod
);

	logic signed [PROD_BITS-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= signed'({1'b0, gain}) * opnd;
		end
	end

	assign prod = prod_q;

endmodule

// File: rtl/core/vfd_dline.sv
// ----------------------------------------------------------------------------
// Delay line store
// Single port sample memory with a registered read and a clearing sweep.
// ----------------------------------------------------------------------------
module vfd_dline import vfd_pkg::*; #(
	parameter int DELAY_DEPTH = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dl_req_t                       req,
	output logic signed [SAMPLE_BITS-1:0] rd_data,
	output logic                          busy
);

	localparam int MEM_DEPTH = (DELAY_DEPTH < POS_SPAN) ? DELAY_DEPTH : POS_SPAN;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

	logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [AW-1:0]          cnt_q;
	logic                   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (req.clr) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[cnt_q] <= '0;
		end else if (req.wr) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_q <= mem[req.addr[AW-1:0]];
		end
	end

	assign rd_data = signed'(rd_q);
	assign busy    = busy_q;

endmodule

// File: rtl/core/voice_filter_delay_core.sv
// ----------------------------------------------------------------------------
// Voice filter delay core
// One voice's inverting one-pole, lowpass, highpass, feedback delay and volume.
// ----------------------------------------------------------------------------
// Each request carries one signed 24-bit sample and gives one result. All
// gain products run through a single shared multiplier under a small
// sequencer. A sample takes least time with the inverting stage and the
// delay both off and most in new mode with both on and the fold applied;
// legacy mode, with no fold, stays below that. The input is not ready
// while a sample is in work. The delay memory holds min(DELAY_DEPTH, 65536)
// entries; after reset and after every delay_length write it is cleared one
// entry per cycle, and no sample is taken meanwhile. Configuration writes
// are taken at any time but belong to idle periods. A finished result waits
// in an output register until it is taken.
`include "assert_macros.svh"

module voice_filter_delay_core import vfd_pkg::*; #(
	parameter int DELAY_DEPTH = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	vfd_in_if.sink              in_ch,
	vfd_out_if.source           out_ch,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [GAIN_BITS-1:0] cfg_data
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_P_IND = 5'd1;
	localparam logic [4:0] S_M_IND = 5'd2;
	localparam logic [4:0] S_C_IND = 5'd3;
	localparam logic [4:0] S_P_LP  = 5'd4;
	localparam logic [4:0] S_M_LP  = 5'd5;
	localparam logic [4:0] S_C_LP  = 5'd6;
	localparam logic [4:0] S_M_HP  = 5'd7;
	localparam logic [4:0] S_C_HP  = 5'd8;
	localparam logic [4:0] S_M_DL  = 5'd9;
	localparam logic [4:0] S_C_DL  = 5'd10;
	localparam logic [4:0] S_P_FLD = 5'd11;
	localparam logic [4:0] S_M_FLD = 5'd12;
	localparam logic [4:0] S_C_FLD = 5'd13;
	localparam logic [4:0] S_R_FLD = 5'd14;
	localparam logic [4:0] S_F_FLD = 5'd15;
	localparam logic [4:0] S_M_VOL = 5'd16;
	localparam logic [4:0] S_C_VOL = 5'd17;

	// The fold works on u = s + 32767 + 64 * 131068, which is positive and
	// below 2^25, so multiplying by 32769 / 2^32 gives the quotient or one less.
	localparam int FOLD_LIMIT = 32767;
	localparam int FOLD_WRAPS = 64;
	localparam logic signed [OP_BITS-1:0] FOLD_M      = OP_BITS'(FOLD_LIMIT);
	localparam logic signed [OP_BITS-1:0] FOLD_HALF   = OP_BITS'(2 * FOLD_LIMIT);
	localparam logic signed [OP_BITS-1:0] FOLD_PERIOD = OP_BITS'(4 * FOLD_LIMIT);
	localparam logic signed [OP_BITS-1:0] FOLD_OFS    =
		OP_BITS'(FOLD_LIMIT + FOLD_WRAPS * 4 * FOLD_LIMIT);
	localparam logic [GAIN_BITS-1:0] FOLD_RECIP = 16'd32769;
	localparam int FOLD_SHIFT = 32;

	logic                   legacy_q;
	logic [GAIN_BITS-1:0]   smooth_q;
	logic [GAIN_BITS-1:0]   hp_share_q;
	logic [GAIN_BITS-1:0]   ind_recip_q;
	logic [GAIN_BITS-1:0]   dl_gain_q;
	logic [POS_BITS-1:0]    dl_len_q;
	logic [GAIN_BITS-1:0]   volume_q;

	logic [4:0]                    state_q;
	logic signed [SAMPLE_BITS-1:0] lp_q;
	logic signed [SAMPLE_BITS-1:0] ind_q;
	logic [POS_BITS-1:0]           pos_q;
	logic                          use_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic signed [OP_BITS-1:0]     wv_q;
	logic signed [OP_BITS-1:0]     op_q;
	logic [POS_BITS-1:0]           dp_q;

	logic                          accept;
	logic                          len_wr;
	logic                          ind_en;
	logic                          slot_free;
	logic [POS_BITS-1:0]           len_eff;
	logic [POS_BITS-1:0]           pos_eff;
	logic [POS_BITS-1:0]           dp_next;
	logic [POS_BITS:0]             pos_inc;
	logic                          mul_en;
	logic [GAIN_BITS-1:0]          mul_gain;
	logic signed [OP_BITS-1:0]     mul_opnd;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [SAMPLE_BITS-1:0] dl_rd;
	logic                          dl_busy;
	dl_req_t                       dl_req;

	logic signed [PROD_BITS-1:0]   rnd15;
	logic signed [PROD_BITS-1:0]   rnd12;
	logic signed [SAMPLE_BITS-1:0] ind_new;
	logic signed [SAMPLE_BITS-1:0] lp_new;
	logic signed [PROD_BITS-1:0]   hp_y;
	logic signed [SAMPLE_BITS-1:0] dl_sub;
	logic signed [SAMPLE_BITS-1:0] dl_keep;
	logic signed [PROD_BITS-1:0]   dl_add;
	logic signed [PROD_BITS-1:0]   fq;
	logic signed [PROD_BITS-1:0]   frem;
	logic signed [SAMPLE_BITS-1:0] vol_out;

	assign len_wr    = cfg_we && (cfg_index == REG_DELAY_LENGTH);
	assign accept    = in_ch.valid && in_ch.ready;
	assign ind_en    = (ind_recip_q != '0);
	assign slot_free = !out_valid_q || out_ch.ready;

	assign len_eff = ({16'b0, dl_len_q} > 32'(DELAY_DEPTH)) ? POS_BITS'(DELAY_DEPTH)
		: dl_len_q;
	assign pos_eff = in_ch.restart ? '0 : pos_q;
	assign dp_next = (pos_eff < len_eff) ? pos_eff : '0;
	assign pos_inc = {1'b0, dp_q} + (POS_BITS + 1)'(1);

	assign in_ch.ready   = (state_q == S_IDLE) && !dl_busy && !len_wr;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.sample_out = out_data_q;

	always_comb begin
		rnd15   = round_shift(prod, Q_GAIN);
		rnd12   = round_shift(prod, Q_VOL);
		ind_new = sat_sample(-rnd15);
		lp_new  = sat_sample(PROD_BITS'(lp_q) + rnd15);
		hp_y    = PROD_BITS'(lp_q) - rnd15;
		dl_sub  = sat_sample(PROD_BITS'(wv_q) - rnd15);
		dl_keep = sat_sample(PROD_BITS'(wv_q));
		dl_add  = PROD_BITS'(wv_q) + rnd15;
		fq      = prod >>> FOLD_SHIFT;
		frem    = PROD_BITS'(op_q) - (fq <<< 17) + (fq <<< 2);
		vol_out = sat_sample(rnd12);
	end

	always_comb begin
		mul_en   = 1'b1;
		mul_gain = '0;
		mul_opnd = op_q;
		unique case (state_q)
			S_M_IND: begin
				mul_gain = ind_recip_q;
			end
			S_M_LP: begin
				mul_gain = smooth_q;
			end
			S_M_HP: begin
				mul_gain = hp_share_q;
				mul_opnd = OP_BITS'(lp_q);
			end
			S_M_DL: begin
				mul_gain = dl_gain_q;
				mul_opnd = OP_BITS'(dl_rd);
			end
			S_M_FLD: begin
				mul_gain = FOLD_RECIP;
			end
			S_M_VOL: begin
				mul_gain = volume_q;
				mul_opnd = wv_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		dl_req.rd    = accept;
		dl_req.wr    = (state_q == S_C_DL);
		dl_req.clr   = len_wr;
		dl_req.addr  = accept ? dp_next : dp_q;
		dl_req.wdata = legacy_q ? dl_keep : dl_sub;
	end

	vfd_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.gain (mul_gain),
		.opnd (mul_opnd),
		.prod (prod)
	);

	vfd_dline #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_dline (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dl_req),
		.rd_data (dl_rd),
		.busy    (dl_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legacy_q    <= 1'b0;
			smooth_q    <= 16'd32768;
			hp_share_q  <= '0;
			ind_recip_q <= '0;
			dl_gain_q   <= '0;
			dl_len_q    <= '0;
			volume_q    <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEGACY_MODE:    legacy_q    <= cfg_data[0];
				REG_SMOOTHING_GAIN: smooth_q    <= cfg_data;
				REG_HIGHPASS_SHARE: hp_share_q  <= cfg_data;
				REG_INDUCTOR_RECIP: ind_recip_q <= cfg_data;
				REG_DELAY_GAIN:     dl_gain_q   <= cfg_data;
				REG_DELAY_LENGTH:   dl_len_q    <= cfg_data;
				REG_VOICE_VOLUME:   volume_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lp_q        <= '0;
			ind_q       <= '0;
			pos_q       <= '0;
			use_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_C_VOL) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						use_q <= (len_eff != '0);
						if (in_ch.restart) begin
							pos_q <= '0;
						end
						state_q <= (!legacy_q && ind_en) ? S_P_IND : S_P_LP;
					end
				end
				S_P_IND: state_q <= S_M_IND;
				S_M_IND: state_q <= S_C_IND;
				S_C_IND: begin
					ind_q <= ind_new;
					if (!legacy_q) begin
						state_q <= S_P_LP;
					end else begin
						state_q <= use_q ? S_M_DL : S_M_VOL;
					end
				end
				S_P_LP: state_q <= S_M_LP;
				S_M_LP: state_q <= S_C_LP;
				S_C_LP: begin
					lp_q    <= lp_new;
					state_q <= S_M_HP;
				end
				S_M_HP: state_q <= S_C_HP;
				S_C_HP: begin
					if (legacy_q && ind_en) begin
						state_q <= S_P_IND;
					end else begin
						state_q <= use_q ? S_M_DL : S_M_VOL;
					end
				end
				S_M_DL: state_q <= S_C_DL;
				S_C_DL: begin
					pos_q   <= (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[POS_BITS-1:0];
					state_q <= legacy_q ? S_M_VOL : S_P_FLD;
				end
				S_P_FLD: state_q <= S_M_FLD;
				S_M_FLD: state_q <= S_C_FLD;
				S_C_FLD: state_q <= S_R_FLD;
				S_R_FLD: state_q <= S_F_FLD;
				S_F_FLD: state_q <= S_M_VOL;
				S_M_VOL: state_q <= S_C_VOL;
				S_C_VOL: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					wv_q <= OP_BITS'(in_ch.sample_in);
					dp_q <= dp_next;
				end
			end
			S_P_IND: op_q <= wv_q - OP_BITS'(ind_q);
			S_C_IND: wv_q <= OP_BITS'(ind_new);
			S_P_LP:  op_q <= wv_q - OP_BITS'(lp_q);
			S_C_HP:  wv_q <= OP_BITS'(hp_y);
			S_C_DL: begin
				wv_q <= legacy_q ? OP_BITS'(dl_add) : OP_BITS'(dl_sub);
			end
			S_P_FLD: op_q <= wv_q + FOLD_OFS;
			S_C_FLD: op_q <= OP_BITS'(frem);
			S_R_FLD: begin
				if (op_q >= FOLD_PERIOD) begin
					op_q <= op_q - FOLD_PERIOD;
				end
			end
			S_F_FLD: begin
				wv_q <= ((op_q > FOLD_HALF) ? (FOLD_PERIOD - op_q) : op_q) - FOLD_M;
			end
			S_C_VOL: begin
				if (slot_free) begin
					out_data_q <= vol_out;
				end
			end
			default: begin
			end
		endcase
	end

	`VFD_ASSERT(a_accept_starts, clk, arst_n, accept |=> (state_q != S_IDLE), "accepted request did not start work")
	`VFD_ASSERT(a_result_from_volume, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == S_C_VOL), "result raised outside the volume step")
	`VFD_ASSERT(a_pos_step, clk, arst_n, (state_q == S_C_DL) |=> (pos_q == '0 || pos_q == $past(dp_q) + 16'd1), "delay position did not step or wrap")
	`VFD_ASSERT_NEVER(a_delay_when_unused, clk, arst_n, (state_q == S_M_DL) && !use_q, "delay product taken with the delay bypassed")

endmodule

// File: bench/voice_filter_checker.sv
// ----------------------------------------------------------------------------
// Voice filter result checker
// Watches the sample, result and register ports of the voice filter, keeps
// its own copy of the filter state, predicts every result and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module voice_filter_checker import vfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	vfd_in_if                    in_ch,
	vfd_out_if                   out_ch,
	input  logic                 cfg_we,
	input  logic [IDX_BITS-1:0]  cfg_index,
	input  logic [GAIN_BITS-1:0] cfg_data,
	output int                   fail_count,
	output int                   outstanding
);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam longint REFLECT_LIMIT = 32767;

	logic                 legacy;
	logic [GAIN_BITS-1:0] smooth_g;
	logic [GAIN_BITS-1:0] hp_share;
	logic [GAIN_BITS-1:0] ind_recip;
	logic [GAIN_BITS-1:0] echo_gain;
	logic [GAIN_BITS-1:0] echo_len;
	logic [GAIN_BITS-1:0] volume;

	sample_t             lowpass_acc;
	sample_t             inductor_acc;
	sample_t             echo_line [POS_SPAN];
	logic [POS_BITS-1:0] echo_pos;

	sample_t expected_out [$];

	function automatic longint scale_round(input longint gain, input longint x, input int frac);
		longint p;
		p = gain * x + (longint'(1) <<< (frac - 1));
		return p >>> frac;
	endfunction

	function automatic longint clamp(input longint v);
		if (v > SAMPLE_MAX) begin
			return SAMPLE_MAX;
		end
		if (v < SAMPLE_MIN) begin
			return SAMPLE_MIN;
		end
		return v;
	endfunction

	function automatic longint reflect(input longint v);
		longint r;
		r = (v + REFLECT_LIMIT) % (4 * REFLECT_LIMIT);
		if (r < 0) begin
			r = r + 4 * REFLECT_LIMIT;
		end
		if (r > 2 * REFLECT_LIMIT) begin
			r = 4 * REFLECT_LIMIT - r;
		end
		return r - REFLECT_LIMIT;
	endfunction

	function automatic longint invert_stage(input longint x);
		inductor_acc = sample_t'(clamp(-scale_round(ind_recip, x - inductor_acc, Q_GAIN)));
		return inductor_acc;
	endfunction

	function automatic longint smooth_stage(input longint x);
		longint lp;
		lp = lowpass_acc;
		lowpass_acc = sample_t'(clamp(lp + scale_round(smooth_g, x - lp, Q_GAIN)));
		lp = lowpass_acc;
		return lp - scale_round(hp_share, lp, Q_GAIN);
	endfunction

	function automatic sample_t filter_voice_sample(input sample_t smp, input logic rst);
		longint      wv;
		longint      acc;
		int unsigned span;
		int unsigned tap;
		bit          echo_on;
		wv = smp;
		if (rst) begin
			echo_pos = '0;
		end
		span = echo_len;
		if (span > POS_SPAN) begin
			span = POS_SPAN;
		end
		echo_on = (span != 0);
		tap = (echo_pos < span) ? echo_pos : 0;
		if (!legacy) begin
			if (ind_recip != 0) begin
				wv = invert_stage(wv);
			end
			wv = smooth_stage(wv);
			if (echo_on) begin
				wv = clamp(wv - scale_round(echo_gain, echo_line[tap], Q_GAIN));
				echo_line[tap] = sample_t'(wv);
				wv = reflect(wv);
			end
		end else begin
			wv = smooth_stage(wv);
			if (ind_recip != 0) begin
				wv = invert_stage(wv);
			end
			acc = wv;
			if (echo_on) begin
				acc = acc + scale_round(echo_gain, echo_line[tap], Q_GAIN);
				echo_line[tap] = sample_t'(clamp(wv));
			end
			wv = acc;
		end
		if (echo_on) begin
			echo_pos = (tap + 1 >= span) ? '0 : POS_BITS'(tap + 1);
		end
		return sample_t'(clamp(scale_round(volume, wv, Q_VOL)));
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sample_t want;
		if (!arst_n) begin
			legacy = 1'b0;
			smooth_g = 16'd32768;
			hp_share = '0;
			ind_recip = '0;
			echo_gain = '0;
			echo_len = '0;
			volume = 16'd4096;
			lowpass_acc = '0;
			inductor_acc = '0;
			echo_pos = '0;
			foreach (echo_line[i]) begin
				echo_line[i] = '0;
			end
			expected_out.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEGACY_MODE: legacy = cfg_data[0];
					REG_SMOOTHING_GAIN: smooth_g = cfg_data;
					REG_HIGHPASS_SHARE: hp_share = cfg_data;
					REG_INDUCTOR_RECIP: ind_recip = cfg_data;
					REG_DELAY_GAIN: echo_gain = cfg_data;
					REG_DELAY_LENGTH: begin
						echo_len = cfg_data;
						foreach (echo_line[i]) begin
							echo_line[i] = '0;
						end
					end
					REG_VOICE_VOLUME: volume = cfg_data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_out.size() == 0) begin
					$display("%0t checker: sample_out %0d arrived with none expected",
						$time, out_ch.sample_out);
					fail_count = fail_count + 1;
				end else begin
					want = expected_out.pop_front();
					if (out_ch.sample_out !== want) begin
						$display("%0t checker: sample_out expected %0d got %0d",
							$time, want, out_ch.sample_out);
						fail_count = fail_count + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				expected_out.push_back(filter_voice_sample(in_ch.sample_in, in_ch.restart));
			end
		end
		outstanding = expected_out.size();
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Voice filter delay testbench
// Drives samples through the voice filter under a series of register
// settings and handshake pressure; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import vfd_pkg::*;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam int CLK_PERIOD = 8;
	localparam int PROBE_COUNT = 12;
	localparam int PROBES [PROBE_COUNT] = '{8388607, -8388608, 0, -1, 1, 8388607,
		8388607, -8388608, -8388608, 32767, -32768, 98301};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_BITS-1:0]  cfg_index;
	logic [GAIN_BITS-1:0] cfg_data;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   fail_count;
	int                   outstanding;

	vfd_in_if  in_ch ();
	vfd_out_if out_ch ();

	voice_filter_delay_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	voice_filter_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		#(64'd40_000_000);
		$display("tb: failure");
		$finish;
	end

	task automatic set_pressure(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic put_reg(input logic [IDX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic program_voice(input logic leg, input logic [GAIN_BITS-1:0] smooth,
		input logic [GAIN_BITS-1:0] share, input logic [GAIN_BITS-1:0] recip,
		input logic [GAIN_BITS-1:0] dgain, input logic [GAIN_BITS-1:0] dlen,
		input logic [GAIN_BITS-1:0] vol);
		put_reg(REG_LEGACY_MODE, {{(GAIN_BITS - 1){1'b0}}, leg});
		put_reg(REG_SMOOTHING_GAIN, smooth);
		put_reg(REG_HIGHPASS_SHARE, share);
		put_reg(REG_INDUCTOR_RECIP, recip);
		put_reg(REG_DELAY_GAIN, dgain);
		put_reg(REG_VOICE_VOLUME, vol);
		put_reg(REG_DELAY_LENGTH, dlen);
		cfg_we <= 1'b0;
	endtask

	task automatic send_request(input sample_t smp, input logic rst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= smp;
		in_ch.restart <= rst;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(4))
			0: return sample_t'(int'($urandom_range(65534)) - 32767);
			1: return $urandom_range(1) ? sample_t'(8388607) : sample_t'(-8388608);
			2: return sample_t'(int'($urandom_range(4000)) - 2000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_BITS-1:0] pick_length();
		case ($urandom_range(3))
			0: return '0;
			1: return GAIN_BITS'($urandom_range(16, 1));
			2: return 16'd65535;
			default: return GAIN_BITS'($urandom_range(65535));
		endcase
	endfunction

	task automatic run_probes();
		for (int i = 0; i < PROBE_COUNT; i++) begin
			send_request(sample_t'(PROBES[i]), (i == 6) || (i == 9));
		end
	endtask

	task automatic run_random(input int count);
		repeat (count) begin
			send_request(pick_sample(), $urandom_range(9) == 0);
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		in_ch.restart = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEGACY_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		set_pressure(0, 0);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		program_voice(1'b0, 16'd32768, 16'd16384, 16'd40000, 16'd65535, 16'd3, 16'd4096);
		run_probes();
		run_random(48);
		settle();

		set_pressure(73, 0);
		program_voice(1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd5, 16'd65535);
		run_probes();
		run_random(48);
		settle();

		set_pressure(14, 14);
		program_voice(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(30);
		settle();

		set_pressure(0, 73);
		program_voice(1'b0, 16'd65535, 16'd0, 16'd32768, 16'd40000, 16'd65535, 16'd65535);
		run_random(60);
		settle();

		set_pressure(0, 0);
		program_voice(1'b0, 16'd20000, 16'd8000, 16'd50000, 16'd65535, 16'd7, 16'd2048);
		run_random(60);
		settle();

		set_pressure(14, 14);
		program_voice(1'b1, 16'd40000, 16'd30000, 16'd0, 16'd32768, 16'd0, 16'd8192);
		run_random(60);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_pressure(0, 0);
				1: set_pressure(73, 0);
				2: set_pressure(0, 73);
				default: set_pressure(14, 14);
			endcase
			program_voice(1'($urandom_range(1)), GAIN_BITS'($urandom_range(65535)),
				GAIN_BITS'($urandom_range(65535)),
				($urandom_range(3) == 0) ? '0 : GAIN_BITS'($urandom_range(65535)),
				GAIN_BITS'($urandom_range(65535)), pick_length(),
				GAIN_BITS'($urandom_range(65535)));
			run_random(80);
			settle();
		end

		set_pressure(0, 0);
		repeat (40) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
